// ===== rtl/nrmb_pkg.sv =====
package nrmb_pkg;

   localparam int STATE_BITS = 5;
   localparam int SLOT_BITS = 6;
   localparam int VALUE_BITS = 24;
   localparam int ENTRY_BITS = 32;
   localparam int PROD_BITS = 48;
   localparam int SUM_BITS = 56;
   localparam int AVG_BITS = 48;
   localparam int NUM_BITS = 64;

   typedef enum logic [2:0] {
      ACT_LOAD_FREQ = 3'd0,
      ACT_LOAD_RATE = 3'd1,
      ACT_LOAD_MAP  = 3'd2,
      ACT_COMPUTE   = 3'd3,
      ACT_READ_ROW  = 3'd4
   } action_type;

   typedef struct packed {
      logic [2:0]            action;
      logic [STATE_BITS-1:0] row;
      logic [STATE_BITS-1:0] col;
      logic [SLOT_BITS-1:0]  rate_slot;
      logic [VALUE_BITS-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STATE_BITS-1:0]        out_row;
      logic [STATE_BITS-1:0]        out_col;
      logic signed [ENTRY_BITS-1:0] entry;
      logic                         last;
   } rsp_type;

   typedef struct packed {
      logic                start;
      logic [NUM_BITS-1:0] num;
      logic [AVG_BITS-1:0] den;
   } div_cmd_type;

   typedef struct packed {
      logic                done;
      logic [NUM_BITS-1:0] quot;
   } div_rsp_type;

   function automatic logic [ENTRY_BITS-1:0] saturate(input logic [NUM_BITS-1:0] mag,
                                                      input logic neg);
      logic [ENTRY_BITS-1:0] res;
      if (!neg) begin
         res = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[ENTRY_BITS-1:0];
      end else if (mag >= 64'h8000_0000) begin
         res = 32'h8000_0000;
      end else begin
         res = 32'd0 - mag[ENTRY_BITS-1:0];
      end
      return res;
   endfunction

endpackage

// ===== rtl/normalized_rate_matrix_builder_unit.sv =====
// Command-style matrix builder. Loads and unused actions leave the unit idle, so they can be
// issued back to back. A compute walks the matrix with one shared multiplier and one shared
// bit-serial divider. The row sums visit every state pair in turn. The entries are then
// written without the divider when the average rate is zero, or through the divider when it
// is positive. A row read keeps busy high until its last result has been shown: one entry
// is addressed each cycle and its result passes through mat_rd_ff and then rsp_entry_ff.
// Results appear for exactly one cycle under rsp_valid; the receiver cannot stall, so every
// transfer is taken when shown. busy is high while an item is being handled.
module normalized_rate_matrix_builder_unit #(
   parameter int MAX_STATES = 32,
   parameter int MAX_RATES = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  nrmb_pkg::req_type req_data,
   output logic              rsp_valid,
   output nrmb_pkg::rsp_type rsp_data,
   input  logic              csr_write,
   input  logic [5:0]        csr_data
);

   localparam int CAP = (MAX_STATES > 32) ? 32 : MAX_STATES;
   localparam int SB = $clog2(CAP);
   localparam int RCAP = (MAX_RATES > 64) ? 64 : MAX_RATES;
   localparam int RB = (RCAP > 1) ? $clog2(RCAP) : 1;
   localparam int MDEPTH = 1 << (2 * SB);

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_SUMA  = 10'b0000000010,
      ST_SUMB  = 10'b0000000100,
      ST_SUMC  = 10'b0000001000,
      ST_AVG   = 10'b0000010000,
      ST_EA    = 10'b0000100000,
      ST_EB    = 10'b0001000000,
      ST_EC    = 10'b0010000000,
      ST_EDIV  = 10'b0100000000,
      ST_READ  = 10'b1000000000
   } state_type;

   logic [23:0] freq_mem [CAP];
   logic [23:0] rate_mem [RCAP];
   logic [5:0]  map_mem  [MDEPTH];
   logic [31:0] mat_mem  [MDEPTH];
   logic [nrmb_pkg::SUM_BITS-1:0] sum_mem [CAP];

   state_type state_ff, state_in;
   logic [5:0] csr_ff;
   logic [5:0] n_val;
   logic [5:0] i_ff, i_in, j_ff, j_in;
   logic [nrmb_pkg::SUM_BITS-1:0] acc_ff, acc_in;
   logic [nrmb_pkg::AVG_BITS-1:0] avg_ff, avg_in;
   logic [5:0] slot_rd_ff;
   logic [23:0] freq_rd_ff, rate_rd_ff, freq_i_ff;
   logic [nrmb_pkg::SUM_BITS-1:0] sum_rd_ff;
   logic [47:0] prod_ff;
   logic [31:0] mat_rd_ff;
   logic [nrmb_pkg::NUM_BITS-1:0] mag_ff, mag_in;
   logic neg_ff, neg_in;
   logic ph_ff, ph_in;
   logic rv_ff, rv_in, rl_ff, rl_in;
   logic [4:0] rr_ff, rr_in, rc_ff, rc_in;
   logic rsp_valid_ff, rsp_last_ff;
   logic [4:0] rsp_row_ff, rsp_col_ff;
   logic [31:0] rsp_entry_ff;
   logic mat_we;
   logic [31:0] mat_wd;
   nrmb_pkg::div_cmd_type dcmd;
   nrmb_pkg::div_rsp_type drsp;
   logic [SB-1:0] lo_idx, hi_idx, i_idx, j_idx;
   logic [5:0] n_last;

   always_comb begin
      n_val = csr_ff;
      if (n_val > 6'(CAP)) n_val = 6'(CAP);
      if (n_val < 6'd2) n_val = 6'd2;
   end
   assign n_last = n_val - 6'd1;
   assign i_idx = i_ff[SB-1:0];
   assign j_idx = j_ff[SB-1:0];
   assign lo_idx = (i_ff < j_ff) ? i_idx : j_idx;
   assign hi_idx = (i_ff < j_ff) ? j_idx : i_idx;

   nrmb_divider u_div (.clock(clock), .reset(reset), .cmd(dcmd), .rsp(drsp));

   // Memory reads: all registered.
   always_ff @(posedge clock) begin
      freq_rd_ff <= freq_mem[j_idx];
      freq_i_ff <= freq_mem[i_idx];
      slot_rd_ff <= map_mem[{lo_idx, hi_idx}];
      rate_rd_ff <= (32'(slot_rd_ff) < MAX_RATES) ? rate_mem[slot_rd_ff[RB-1:0]] : 24'd0;
      sum_rd_ff <= sum_mem[i_idx];
      mat_rd_ff <= mat_mem[{i_idx, j_idx}];
      prod_ff <= 48'(rate_rd_ff) * 48'(freq_rd_ff);
   end

   // Memory writes.
   always_ff @(posedge clock) begin
      if (start && !busy && state_ff == ST_IDLE) begin
         case (req_data.action)
            nrmb_pkg::ACT_LOAD_FREQ: begin
               if (32'(req_data.row) < MAX_STATES) freq_mem[req_data.row[SB-1:0]] <= req_data.value;
            end
            nrmb_pkg::ACT_LOAD_RATE: begin
               if (32'(req_data.rate_slot) < MAX_RATES)
                  rate_mem[req_data.rate_slot[RB-1:0]] <= req_data.value;
            end
            nrmb_pkg::ACT_LOAD_MAP: begin
               if (32'(req_data.row) < MAX_STATES && 32'(req_data.col) < MAX_STATES)
                  map_mem[{req_data.row[SB-1:0], req_data.col[SB-1:0]}] <= req_data.rate_slot;
            end
            default: begin
            end
         endcase
      end
      if (state_ff == ST_AVG && ph_ff) sum_mem[i_idx] <= acc_ff;
      if (mat_we) mat_mem[{i_idx, j_idx}] <= mat_wd;
   end

   always_comb begin
      state_in = state_ff;
      i_in = i_ff;
      j_in = j_ff;
      acc_in = acc_ff;
      avg_in = avg_ff;
      mag_in = mag_ff;
      neg_in = neg_ff;
      ph_in = 1'b0;
      rv_in = 1'b0;
      rl_in = 1'b0;
      rr_in = rr_ff;
      rc_in = rc_ff;
      mat_we = 1'b0;
      mat_wd = '0;
      dcmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start && !busy) begin
               i_in = '0;
               j_in = '0;
               case (req_data.action)
                  nrmb_pkg::ACT_COMPUTE: begin
                     acc_in = '0;
                     avg_in = '0;
                     state_in = ST_SUMA;
                  end
                  nrmb_pkg::ACT_READ_ROW: begin
                     if (6'(req_data.row) < n_val) begin
                        i_in = 6'(req_data.row);
                        state_in = ST_READ;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         // Row sums: address, map read, rate read, product, accumulate.
         ST_SUMA: state_in = ST_SUMB;
         ST_SUMB: state_in = ST_SUMC;
         ST_SUMC: begin
            ph_in = ph_ff;
            if (!ph_ff) begin
               ph_in = 1'b1;
            end else begin
               ph_in = 1'b0;
               state_in = ST_AVG;
            end
         end
         ST_AVG: begin
            if (!ph_ff) begin
               if (j_ff != i_ff) acc_in = acc_ff + 56'(prod_ff);
               ph_in = 1'b1;
            end else if (j_ff != n_last) begin
               j_in = j_ff + 6'd1;
               state_in = ST_SUMA;
            end else begin
               avg_in = avg_ff + 48'((72'(freq_i_ff) * 72'(acc_ff[55:16])) >> 24);
               acc_in = '0;
               j_in = '0;
               if (i_ff != n_last) begin
                  i_in = i_ff + 6'd1;
                  state_in = ST_SUMA;
               end else begin
                  i_in = '0;
                  state_in = ST_EA;
               end
            end
         end
         ST_EA: state_in = ST_EB;
         ST_EB: state_in = ST_EC;
         ST_EC: begin
            ph_in = 1'b1;
            if (!ph_ff) begin
               state_in = ST_EC;
            end else begin
               if (i_ff == j_ff) begin
                  mag_in = 64'(sum_rd_ff);
                  neg_in = 1'b1;
               end else begin
                  mag_in = 64'(prod_ff);
                  neg_in = 1'b0;
               end
               ph_in = 1'b0;
               state_in = ST_EDIV;
            end
         end
         ST_EDIV: begin
            ph_in = ph_ff;
            if (avg_ff == '0) begin
               mat_we = 1'b1;
               mat_wd = nrmb_pkg::saturate(mag_ff >> 16, neg_ff);
            end else if (!ph_ff) begin
               dcmd.start = 1'b1;
               dcmd.num = mag_ff << 8;
               dcmd.den = avg_ff;
               ph_in = 1'b1;
            end else if (drsp.done) begin
               mat_we = 1'b1;
               mat_wd = nrmb_pkg::saturate(drsp.quot, neg_ff);
            end
            if (mat_we) begin
               ph_in = 1'b0;
               if (j_ff != n_last) begin
                  j_in = j_ff + 6'd1;
                  state_in = ST_EA;
               end else if (i_ff != n_last) begin
                  j_in = '0;
                  i_in = i_ff + 6'd1;
                  state_in = ST_EA;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_READ: begin
            rv_in = 1'b1;
            rr_in = i_ff[4:0];
            rc_in = j_ff[4:0];
            rl_in = (j_ff == n_last);
            if (j_ff == n_last) state_in = ST_IDLE;
            else j_in = j_ff + 6'd1;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         csr_ff <= 6'd32;
         avg_ff <= '0;
         ph_ff <= 1'b0;
         rv_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write) csr_ff <= csr_data;
         avg_ff <= avg_in;
         ph_ff <= ph_in;
         rv_ff <= rv_in;
         rsp_valid_ff <= rv_ff;
      end
      i_ff <= i_in;
      j_ff <= j_in;
      acc_ff <= acc_in;
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      rr_ff <= rr_in;
      rc_ff <= rc_in;
      rl_ff <= rl_in;
      rsp_row_ff <= rr_ff;
      rsp_col_ff <= rc_ff;
      rsp_last_ff <= rl_ff;
      rsp_entry_ff <= mat_rd_ff;
   end

   // The read pipeline keeps busy high until the last transfer has been shown.
   assign busy = (state_ff != ST_IDLE) || rv_ff || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data.out_row = rsp_row_ff;
   assign rsp_data.out_col = rsp_col_ff;
   assign rsp_data.entry = rsp_entry_ff;
   assign rsp_data.last = rsp_last_ff;

endmodule

// ===== rtl/nrmb_divider.sv =====
module nrmb_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  nrmb_pkg::div_cmd_type cmd,
   output nrmb_pkg::div_rsp_type rsp
);

   localparam int NB = nrmb_pkg::NUM_BITS;

   logic [NB-1:0] quot_ff, quot_in;
   logic [NB:0] rem_ff, rem_in;
   logic [nrmb_pkg::AVG_BITS-1:0] den_ff, den_in;
   logic [6:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [NB:0] trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff[NB-1:0], quot_ff[NB-1]};
      if (cmd.start) begin
         quot_in = cmd.num;
         rem_in = '0;
         den_in = cmd.den;
         cnt_in = 7'(NB);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {17'd0, den_ff}) begin
            rem_in = trial - {17'd0, den_ff};
            quot_in = {quot_ff[NB-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quot_in = {quot_ff[NB-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;

endmodule

// ===== rtl/nrmb_checker.sv =====
module nrmb_checker (
   input logic              clock,
   input logic              reset,
   input logic              busy,
   input logic              rsp_valid,
   input nrmb_pkg::rsp_type rsp_data
);

   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result shown while idle");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid) else $error("result right after reset");

   a_col_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |=> rsp_valid &&
      rsp_data.out_col == $past(rsp_data.out_col) + 5'd1)
      else $error("row transfers not contiguous");

   a_row_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |=> $stable(rsp_data.out_row))
      else $error("row index changed inside a row");

endmodule

bind normalized_rate_matrix_builder_unit nrmb_checker u_nrmb_checker (
   .clock(clock), .reset(reset), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_data(rsp_data));
